/* rtl/core/sas_pkg.sv */
`default_nettype none

package sas_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF    = 32;
    localparam int FRAME_ID_BITS_DEF = 16;

    // Request field widths
    localparam int OP_W     = 3;
    localparam int DT_W     = 16;
    localparam int MULT_W   = 12;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 16;
    localparam int S_DATA_W = 56;

    // Result field widths
    localparam int POS_OUT_W = 5;
    localparam int ID_OUT_W  = 16;
    localparam int M_DATA_W  = 24;

    // Configuration
    localparam int MODE_W     = 3;
    localparam int CNT_W      = 6;
    localparam int RATE_W     = 16;
    localparam int PERIOD_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_LIM    = 2**CNT_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

    localparam logic [MODE_W-1:0]   MODE_RST   = 3'd2;
    localparam logic [RATE_W-1:0]   RATE_RST   = 16'd256;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd65536;
    localparam logic [MODE_W-1:0]   MODE_ONCE  = 3'd1;
    localparam logic [MODE_W-1:0]   MODE_LOOP  = 3'd2;

    localparam int MODE_B_ONCE = 0;
    localparam int MODE_B_LOOP = 1;
    localparam int MODE_B_PING = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd0;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_REV = 3'd4;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd5;

    // Time and raw frame arithmetic
    localparam int TIME_W  = 32;
    localparam int RM_W    = RATE_W + MULT_W;
    localparam int PROD_W  = TIME_W + RM_W;
    localparam int RAW_W   = PROD_W - 32;
    localparam int LIMIT_W = PERIOD_W + CNT_W + 1;

    // Remainder unit: REM_STEP quotient bits per cycle
    localparam int REM_STEP   = 7;
    localparam int REM_CYCLES = RAW_W / REM_STEP;
    localparam int REM_CNT_W  = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_rem_rsp;

endpackage

`default_nettype wire

/* rtl/core/sas_ram.sv */
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/sas_rem.sv */
`default_nettype none

// Remainder of the raw frame by the frame count, REM_STEP bits a cycle
module sas_rem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sas_pkg::t_rem_req i_req,
    output sas_pkg::t_rem_rsp      o_rsp
);

    import sas_pkg::*;

    logic [RAW_W-1:0]     r_num, n_num;
    logic [CNT_W-1:0]     r_den, n_den;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [REM_CNT_W-1:0] r_step, n_step;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] rem;
        logic [RAW_W-1:0] num;
        rem    = r_rem;
        num    = r_num;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        for (int k = 0; k < REM_STEP; k++) begin
            t   = {rem, num[RAW_W-1]};
            num = {num[RAW_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t = t - {1'b0, r_den};
            end
            rem = t[CNT_W-1:0];
        end
        if (i_req.start) begin
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num  = num;
            n_rem  = rem;
            n_step = r_step + 1'b1;
            if (r_step == REM_CNT_W'(REM_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/core/sprite_animation_sequencer.sv */
// Steps: an advance request passes through the multiply, the 7-bit-per-cycle remainder
// unit, the update, the table read and the result; other requests skip the first two.
// Requests are taken one at a time: a new one is accepted only in idle, once the last
// result has gone into the output register, which holds while the receiver stalls.
// Reset: synchronous, active low; clears playback state and restores register defaults.
// Frame table contents are undefined until loaded; there is no clearing pass.
`default_nettype none

module sprite_animation_sequencer #(
    parameter int MAX_FRAMES    = sas_pkg::MAX_FRAMES_DEF,
    parameter int FRAME_ID_BITS = sas_pkg::FRAME_ID_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // time_delta[15:0], speed[27:16], reverse_flag[28], table_index[33:29],
    // table_value[49:34], zero[55:50]
    input  wire logic [sas_pkg::S_DATA_W-1:0]   i_s_tdata,
    // op[2:0]
    input  wire logic [sas_pkg::OP_W-1:0]       i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // frame_position[4:0], frame_id[20:5], complete[21], paused_now[22], frame_valid[23]
    output logic      [sas_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sas_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import sas_pkg::*;

    localparam int CNT_MAX = (MAX_FRAMES < CNT_LIM) ? MAX_FRAMES : CNT_LIM;
    localparam int POS_W   = $clog2(CNT_MAX);
    localparam int AW      = $clog2(MAX_FRAMES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_EXEC = 6'b001000,
        S_READ = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [MODE_W-1:0]   r_mode;
    logic [CNT_W-1:0]    r_count;
    logic [RATE_W-1:0]   r_rate;
    logic [PERIOD_W-1:0] r_period;

    // playback state
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic              r_paused, n_paused;
    logic              r_rev, n_rev;
    logic              r_half, n_half;
    logic [RAW_W-1:0]  r_last, n_last;
    logic [POS_W-1:0]  r_pos, n_pos;

    // request and working registers
    logic [OP_W-1:0]    r_op, n_op;
    logic               r_rev_in, n_rev_in;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [RM_W-1:0]    r_rm, n_rm;
    logic [RAW_W-1:0]   r_raw, n_raw;
    logic [LIMIT_W-1:0] r_limit, n_limit;

    logic                r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0] r_m_data, n_m_data;

    logic [DT_W-1:0]   w_dt;
    logic [MULT_W-1:0] w_mult;
    logic              w_acc;
    logic [TIME_W:0]   w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [CNT_W-1:0]  w_cnt, w_cm1;

    logic [RAW_W-1:0] w_fr;
    logic             w_pass, w_half_n, w_big;
    logic [CNT_W:0]   w_lim, w_r;
    logic [CNT_W-1:0] w_rm2, w_p, w_pfin;

    logic                     w_we;
    logic [FRAME_ID_BITS-1:0] w_rdata;
    logic                     w_done;

    t_rem_req w_rem_req;
    t_rem_rsp w_rem_rsp;

    assign w_dt   = i_s_tdata[DT_W-1:0];
    assign w_mult = i_s_tdata[DT_W+MULT_W-1:DT_W];
    assign w_acc  = i_s_tvalid && o_s_tready;
    assign w_sum  = {1'b0, r_elapsed} + {{(TIME_W+1-DT_W){1'b0}}, w_dt};
    assign w_prod = PROD_W'(r_elapsed) * PROD_W'(r_rm);

    assign w_cnt = (r_count > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : r_count;
    assign w_cm1 = w_cnt - 1'b1;

    assign w_rem_req.start = (r_state == S_MUL);
    assign w_rem_req.num   = w_prod[PROD_W-1:32];
    assign w_rem_req.den   = w_cnt;

    // Position update for an advance; only used when the count is nonzero
    always_comb begin
        if (r_mode[MODE_B_ONCE]) begin
            w_fr = (r_raw < RAW_W'(w_cnt)) ? r_raw : RAW_W'(w_cm1);
        end else if (r_mode[MODE_B_LOOP]) begin
            w_fr = RAW_W'(w_rem_rsp.rem);
        end else begin
            w_fr = r_raw;
        end
        // a pass counts once, on the first landing on a new multiple
        w_pass = (r_raw != '0) && (w_rem_rsp.rem == '0) && (r_raw != r_last);
        if (r_mode[MODE_B_PING] && w_pass) begin
            w_half_n = r_mode[MODE_B_ONCE] ? 1'b1 : ~r_half;
        end else begin
            w_half_n = r_half;
        end
        w_lim = {w_cnt, 1'b0} - 1'b1;
        w_r   = (r_raw < RAW_W'(w_lim)) ? r_raw[CNT_W:0] : w_lim;
        w_rm2 = (w_r >= {1'b0, w_cnt}) ? CNT_W'(w_r - {1'b0, w_cnt}) : w_r[CNT_W-1:0];
        w_big = w_fr > RAW_W'(w_cm1);
        if (r_mode[MODE_B_PING] && w_half_n) begin
            if (r_mode[MODE_B_ONCE]) begin
                w_p = w_cm1 - w_rm2;
            end else begin
                w_p = w_big ? '0 : w_cm1 - w_fr[CNT_W-1:0];
            end
        end else begin
            w_p = w_big ? w_cm1 : w_fr[CNT_W-1:0];
        end
        w_pfin = r_rev ? w_cm1 - w_p : w_p;
    end

    assign w_done = ((r_mode == MODE_ONCE) || (r_mode == MODE_LOOP))
                    && (r_elapsed > TIME_W'(r_limit));

    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_paused  = r_paused;
        n_rev     = r_rev;
        n_half    = r_half;
        n_last    = r_last;
        n_pos     = r_pos;
        n_op      = r_op;
        n_rev_in  = r_rev_in;
        n_idx     = r_idx;
        n_val     = r_val;
        n_rm      = r_rm;
        n_raw     = r_raw;
        n_limit   = r_limit;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        w_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op     = i_s_tuser;
                    n_rev_in = i_s_tdata[DT_W+MULT_W];
                    n_idx    = i_s_tdata[DT_W+MULT_W+IDX_W:DT_W+MULT_W+1];
                    n_val    = i_s_tdata[DT_W+MULT_W+IDX_W+VAL_W:DT_W+MULT_W+IDX_W+1];
                    n_rm     = RM_W'(r_rate) * RM_W'(w_mult);
                    if (i_s_tuser == OP_ADVANCE && !r_paused) begin
                        n_elapsed = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
                        n_state   = S_MUL;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_MUL: begin
                n_raw   = w_prod[PROD_W-1:32];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rem_rsp.done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_READ;
                unique case (r_op)
                    OP_ADVANCE: begin
                        if (!r_paused) begin
                            n_last = r_raw;
                            if (w_cnt != '0) begin
                                n_half = w_half_n;
                                n_pos  = POS_W'(w_pfin);
                            end
                        end
                    end
                    OP_RESET: begin
                        n_elapsed = '0;
                        n_paused  = 1'b0;
                        n_half    = 1'b0;
                        n_last    = '0;
                        n_pos     = '0;
                    end
                    OP_PAUSE:  n_paused = 1'b1;
                    OP_RESUME: n_paused = 1'b0;
                    OP_SET_REV: begin
                        if (r_rev_in != r_rev) begin
                            n_rev     = r_rev_in;
                            n_elapsed = '0;
                            n_last    = '0;
                            if (w_cnt != '0) begin
                                n_pos = r_rev_in ? POS_W'(w_cm1) : '0;
                            end
                        end
                    end
                    OP_LOAD: w_we = (r_idx < MAX_FRAMES);
                    default: ;
                endcase
            end
            S_READ: begin
                n_limit = LIMIT_W'(r_period) * LIMIT_W'({1'b0, w_cnt} + 1'b1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {(w_cnt != '0), r_paused, w_done,
                                 (w_cnt != '0) ? ID_OUT_W'(w_rdata) : {ID_OUT_W{1'b0}},
                                 POS_OUT_W'(r_pos)};
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_elapsed <= '0;
            r_paused  <= 1'b0;
            r_rev     <= 1'b0;
            r_half    <= 1'b0;
            r_last    <= '0;
            r_pos     <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_elapsed <= n_elapsed;
            r_paused  <= n_paused;
            r_rev     <= n_rev;
            r_half    <= n_half;
            r_last    <= n_last;
            r_pos     <= n_pos;
        end
        r_op     <= n_op;
        r_rev_in <= n_rev_in;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_rm     <= n_rm;
        r_raw    <= n_raw;
        r_limit  <= n_limit;
        r_m_data <= n_m_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_count  <= '0;
            r_rate   <= RATE_RST;
            r_period <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_COUNT:  r_count  <= i_cfg_data[CNT_W-1:0];
                CFG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
            endcase
        end
    end

    sas_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    sas_ram #(
        .WIDTH (FRAME_ID_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (FRAME_ID_BITS'(r_val)),
        .i_raddr (AW'(r_pos)),
        .o_rdata (w_rdata)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/sas_checker.sv */
`default_nettype none

module sas_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_tvalid,
    input wire logic                         o_s_tready,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [sas_pkg::M_DATA_W-1:0] o_m_tdata
);

    // no result pending straight after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // one request at a time: ready drops after each acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while busy");

    // no frames means frame_id reads as zero
    a_empty_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[23] |-> (o_m_tdata[20:5] == 16'd0))
        else $error("frame_id nonzero without frames");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (.*);

`default_nettype wire

/* sim/sprite_animation_sequencer_tb.sv */
`timescale 1ns / 100ps

module sprite_animation_sequencer_tb;
    import sas_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_TARGET = 1280;
    localparam int SOAK_REQUESTS = 64;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic REG = 1'b1;
    localparam logic REQ = 1'b0;

    // fields from the highest bit down, as on o_m_tdata
    typedef struct packed {
        logic                 frame_valid;
        logic                 paused_now;
        logic                 complete;
        logic [ID_OUT_W-1:0]  frame_id;
        logic [POS_OUT_W-1:0] frame_position;
    } t_frame_result;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [OP_W-1:0]       op;
        logic [DT_W-1:0]       dt;
        logic [MULT_W-1:0]     mult;
        logic                  rev;
        logic [IDX_W-1:0]      slot;
        logic [VAL_W-1:0]      id_val;
        logic                  typed;
        t_frame_result         want;
    } t_step_row;

    localparam t_frame_result NONE       = '0;
    localparam t_frame_result PAUSED_RES = '{1'b0, 1'b1, 1'b0, 16'h0000, 5'd0};
    localparam t_frame_result DONE_RES   = '{1'b0, 1'b0, 1'b1, 16'h0000, 5'd0};

    // rows with typed=1 carry their own result; the rest go through the predictor
    localparam t_step_row DIRECTED [45] = '{
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hFFFF, 12'hFFF, 1'b1, 5'd31, 16'hFFFF, 1'b1, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_SPARE_A, 16'hFFFF, 12'hFFF, 1'b1, 5'd31, 16'hFFFF, 1'b1, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_SPARE_B, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_PAUSE, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1,
          PAUSED_RES},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hFFFF, 12'hFFF, 1'b0, 5'd0, 16'h0000, 1'b1,
          PAUSED_RES},
        '{REQ, CFG_MODE, 24'h0, OP_RESUME, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1, NONE},
        // time just past one period with no frames: complete in loop mode
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h0002, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1,
          DONE_RES},
        '{REQ, CFG_MODE, 24'h0, OP_RESET, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_LOAD, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b1, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_LOAD, 16'h0000, 12'h000, 1'b0, 5'd31, 16'hFFFF, 1'b1, NONE},
        // play once, oversized count, extreme rate and period
        '{REG, CFG_MODE, 24'h000001, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_COUNT, 24'h00003F, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h00FFFF, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_PERIOD, 24'hFFFFFF, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hFFFF, 12'hFFF, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_SET_REV, 16'h0000, 12'h000, 1'b1, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_SET_REV, 16'h0000, 12'h000, 1'b1, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h0001, 12'h001, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_SET_REV, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        // loop with ping-pong: raw 1, 3 (new pass), 3 again (no pass), 6 (new pass)
        '{REG, CFG_MODE, 24'h000006, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_COUNT, 24'h000003, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h000100, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_PERIOD, 24'h000000, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h4000, 12'h400, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h8000, 12'h400, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h0000, 12'h400, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hC000, 12'h400, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        // play once with ping-pong, single frame, zero rate then unit rate
        '{REG, CFG_MODE, 24'h000005, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_COUNT, 24'h000001, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h000000, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h1234, 12'h100, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h000100, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hFFFF, 12'h800, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        // ping-pong with neither once nor loop
        '{REG, CFG_MODE, 24'h000004, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_COUNT, 24'h000002, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h000200, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_PERIOD, 24'h0000FF, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'h8000, 12'h200, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_RESET, 16'h0000, 12'h000, 1'b0, 5'd0, 16'h0000, 1'b0, NONE},
        // plain clamp, full table, smallest rate and period
        '{REG, CFG_MODE, 24'h000000, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_COUNT, 24'h000020, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_RATE, 24'h000001, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REG, CFG_PERIOD, 24'h000001, OP_ADVANCE, 16'h0, 12'h0, 1'b0, 5'd0, 16'h0, 1'b0, NONE},
        '{REQ, CFG_MODE, 24'h0, OP_ADVANCE, 16'hFFFF, 12'hFFF, 1'b0, 5'd0, 16'h0000, 1'b0, NONE}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow configuration and playback state
    logic [MODE_W-1:0]   cfg_mode   = MODE_RST;
    logic [CNT_W-1:0]    cfg_frames = '0;
    logic [RATE_W-1:0]   cfg_rate   = RATE_RST;
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;

    logic [31:0]        elapsed_q16 = '0;
    logic               paused      = 1'b0;
    logic               reversed    = 1'b0;
    logic               return_pass = 1'b0;
    logic [27:0]        prev_raw    = '0;
    logic [4:0]         position    = '0;
    logic [VAL_W-1:0]   frame_ids [MAX_FRAMES_DEF];

    t_frame_result pending_frames [$];
    t_frame_result want_frame;
    t_frame_result got_frame;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int mismatches      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int stall_cycles    = 0;

    sprite_animation_sequencer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Applies one request to the shadow state, returns the result it should give
    function automatic t_frame_result frame_after(input logic [OP_W-1:0] op,
                                                  input logic [DT_W-1:0] dt,
                                                  input logic [MULT_W-1:0] mult,
                                                  input logic rev,
                                                  input logic [IDX_W-1:0] slot,
                                                  input logic [VAL_W-1:0] id_val);
        int unsigned   cnt;
        logic [63:0]   sum;
        logic [63:0]   raw;
        logic [63:0]   lim;
        logic [63:0]   span;
        longint        frame;
        t_frame_result res;

        cnt = (cfg_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(cfg_frames);
        case (op)
            OP_ADVANCE: begin
                if (!paused) begin
                    sum = 64'(elapsed_q16) + 64'(dt);
                    elapsed_q16 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    raw = ((64'(elapsed_q16) * 64'(cfg_rate)) * 64'(mult)) >> 32;
                    raw = raw & 64'h0FFF_FFFF;
                    if (cnt == 0) begin
                        prev_raw = raw[27:0];
                    end else begin
                        if (cfg_mode[MODE_B_ONCE]) begin
                            frame = (raw < 64'(cnt)) ? longint'(raw) : longint'(cnt) - 1;
                        end else if (cfg_mode[MODE_B_LOOP]) begin
                            frame = longint'(raw % 64'(cnt));
                        end else begin
                            frame = longint'(raw);
                        end
                        if (cfg_mode[MODE_B_PING]) begin
                            // a pass counts only on first arrival at a new multiple
                            if (raw != 0 && raw % 64'(cnt) == 0 && raw[27:0] != prev_raw) begin
                                return_pass = cfg_mode[MODE_B_ONCE] ? 1'b1 : ~return_pass;
                            end
                            if (return_pass) begin
                                if (cfg_mode[MODE_B_ONCE]) begin
                                    lim   = 64'(2 * cnt - 1);
                                    span  = (raw < lim) ? raw : lim;
                                    frame = longint'(cnt) - 1 - longint'(span % 64'(cnt));
                                end else begin
                                    frame = longint'(cnt) - 1 - frame;
                                end
                            end
                        end
                        prev_raw = raw[27:0];
                        if (frame < 0) frame = 0;
                        if (frame > longint'(cnt) - 1) frame = longint'(cnt) - 1;
                        if (reversed) frame = longint'(cnt) - 1 - frame;
                        position = frame[4:0];
                    end
                end
            end
            OP_RESET: begin
                elapsed_q16 = '0;
                paused      = 1'b0;
                return_pass = 1'b0;
                prev_raw    = '0;
                position    = '0;
            end
            OP_PAUSE:  paused = 1'b1;
            OP_RESUME: paused = 1'b0;
            OP_SET_REV: begin
                if (rev != reversed) begin
                    reversed    = rev;
                    elapsed_q16 = '0;
                    prev_raw    = '0;
                    if (cnt != 0) position = rev ? 5'(cnt - 1) : 5'd0;
                end
            end
            OP_LOAD: frame_ids[slot] = id_val;
            default: ;
        endcase

        sum = 64'(cfg_period) * 64'(cnt + 1);
        res.complete       = (cfg_mode == MODE_ONCE || cfg_mode == MODE_LOOP) &&
                             (64'(elapsed_q16) > sum);
        res.frame_valid    = (cnt != 0);
        res.paused_now     = paused;
        res.frame_position = position;
        res.frame_id       = (cnt != 0) ? frame_ids[position] : '0;
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MODE:   cfg_mode   = val[MODE_W-1:0];
            CFG_COUNT:  cfg_frames = val[CNT_W-1:0];
            CFG_RATE:   cfg_rate   = val[RATE_W-1:0];
            CFG_PERIOD: cfg_period = val[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    // Called on a falling edge; returns on the falling edge after acceptance
    task automatic put_request(input logic [OP_W-1:0] op, input logic [DT_W-1:0] dt,
                               input logic [MULT_W-1:0] mult, input logic rev,
                               input logic [IDX_W-1:0] slot, input logic [VAL_W-1:0] id_val,
                               input logic typed, input t_frame_result want);
        t_frame_result predicted;

        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, id_val, slot, rev, mult, dt};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        predicted = frame_after(op, dt, mult, rev, slot, id_val);
        pending_frames.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, val);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings();
        int          pick;
        logic [23:0] val;

        // junk above the field width must be dropped by the block
        val = 24'($urandom);
        val[MODE_W-1:0] = 3'($urandom_range(7));
        write_register(CFG_MODE, val);

        pick = $urandom_range(99);
        val  = 24'($urandom);
        if (pick < 8)       val[CNT_W-1:0] = '0;
        else if (pick < 18) val[CNT_W-1:0] = 6'($urandom_range(32, 63));
        else                val[CNT_W-1:0] = 6'($urandom_range(1, 12));
        write_register(CFG_COUNT, val);

        pick = $urandom_range(99);
        val  = 24'($urandom);
        if (pick < 5)       val[RATE_W-1:0] = '0;
        else if (pick < 10) val[RATE_W-1:0] = '1;
        else                val[RATE_W-1:0] = 16'($urandom_range(32, 2048));
        write_register(CFG_RATE, val);

        pick = $urandom_range(99);
        if (pick < 5)       val = '0;
        else if (pick < 10) val = '1;
        else if (pick < 15) val = 24'($urandom);
        else                val = 24'($urandom_range(24'h001000, 24'h030000));
        write_register(CFG_PERIOD, val);
    endtask

    task automatic send_random_request();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [DT_W-1:0]   dt;
        logic [MULT_W-1:0] mult;

        pick = $urandom_range(99);
        if (pick < 68)      op = OP_ADVANCE;
        else if (pick < 73) op = OP_RESET;
        else if (pick < 78) op = OP_PAUSE;
        else if (pick < 85) op = OP_RESUME;
        else if (pick < 91) op = OP_SET_REV;
        else if (pick < 96) op = OP_LOAD;
        else                op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        dt   = 16'($urandom);
        mult = 12'($urandom);
        // keep most advances slow enough that frames step through passes
        if (op == OP_ADVANCE && $urandom_range(9) != 0) begin
            dt   = 16'($urandom_range(16'h6000));
            mult = 12'($urandom_range(12'h040, 12'h300));
        end
        put_request(op, dt, mult, 1'($urandom), 5'($urandom), 16'($urandom), 1'b0, NONE);
    endtask

    // receiver: random back-pressure, plus one long hold when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_frame = m_tdata;
            if (pending_frames.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                want_frame = pending_frames.pop_front();
                results_checked++;
                if (got_frame.frame_position != want_frame.frame_position) begin
                    $error("frame_position: expected %0d, actual %0d",
                           want_frame.frame_position, got_frame.frame_position);
                    mismatches++;
                end
                if (got_frame.frame_id != want_frame.frame_id) begin
                    $error("frame_id: expected %h, actual %h",
                           want_frame.frame_id, got_frame.frame_id);
                    mismatches++;
                end
                if (got_frame.complete != want_frame.complete) begin
                    $error("complete: expected %0d, actual %0d",
                           want_frame.complete, got_frame.complete);
                    mismatches++;
                end
                if (got_frame.paused_now != want_frame.paused_now) begin
                    $error("paused_now: expected %0d, actual %0d",
                           want_frame.paused_now, got_frame.paused_now);
                    mismatches++;
                end
                if (got_frame.frame_valid != want_frame.frame_valid) begin
                    $error("frame_valid: expected %0d, actual %0d",
                           want_frame.frame_valid, got_frame.frame_valid);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles in which no channel moves anything
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     stall_cycles, pending_frames.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n_directed;
        int n_random;
        int n_soak;
        int phase_no;
        int phase_len;

        n_directed = 0;
        n_random   = 0;
        n_soak     = 0;
        phase_no   = 0;
        for (int i = 0; i < MAX_FRAMES_DEF; i++) frame_ids[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole table first so no lookup ever hits an unloaded slot
        for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
            put_request(OP_LOAD, 16'($urandom), 12'($urandom), 1'($urandom), 5'(i),
                        16'($urandom), 1'b0, NONE);
        end

        for (int r = 0; r < $size(DIRECTED); r++) begin
            if (DIRECTED[r].is_cfg) begin
                write_register(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
            end else begin
                put_request(DIRECTED[r].op, DIRECTED[r].dt, DIRECTED[r].mult, DIRECTED[r].rev,
                            DIRECTED[r].slot, DIRECTED[r].id_val, DIRECTED[r].typed,
                            DIRECTED[r].want);
                n_directed++;
            end
        end

        while (n_random < RANDOM_TARGET) begin
            pick_settings();
            phase_len = $urandom_range(60, 140);
            steady = (phase_no == 2);
            for (int k = 0; k < phase_len; k++) begin
                if (phase_no == 4 && k == 20) hold_req = 1'b1;
                if (phase_no == 6 && k == 40) wait_drained();
                send_random_request();
                n_random++;
            end
            phase_no++;
        end
        steady = 1'b0;

        // back-to-back maximum steps at the largest rate and period
        write_register(CFG_MODE, 24'(MODE_LOOP));
        write_register(CFG_COUNT, 24'd5);
        write_register(CFG_RATE, 24'h00FFFF);
        write_register(CFG_PERIOD, 24'hFFFFFF);
        steady = 1'b1;
        put_request(OP_RESET, '0, '0, 1'b0, '0, '0, 1'b0, NONE);
        for (int k = 0; k < SOAK_REQUESTS; k++) begin
            put_request(OP_ADVANCE, 16'hFFFF, 12'($urandom), 1'($urandom), 5'($urandom),
                        16'($urandom), 1'b0, NONE);
            n_soak++;
        end
        steady = 1'b0;

        wait_drained();
        if (pending_frames.size() != 0) begin
            $error("%0d results never arrived", pending_frames.size());
            mismatches++;
        end

        $display("Ran %0d directed, %0d random and %0d long-step requests over %0d settings",
                 n_directed, n_random, n_soak, cfg_writes);
        $display("Checked %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
